// ===== hdl/apq_pkg.sv =====
// Shared types and constants for the unsorted-array minimum priority queue.
// No dependencies; used by apq_front, apq_core and the top level.
`default_nettype none

package apq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] entry_pri;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/array_min_priority_queue.sv =====
// Enqueue, full and empty: the word passes the input queue and then the output register; one
// word per cycle while the output is free. Dequeue: a pop step, a scan of every entry held
// through the single read port of the entry store, a drain step for the read latency and a
// step to write the last entry into the vacated slot; no other word is taken meanwhile.
// Output stalls hold the write step; a two-entry input queue decouples the input.
// Reset (aresetn low, synchronous) empties the queue; stored entries are not cleared.
`default_nettype none

module array_min_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // [31:0] value, [63:32] priority_req
    input  wire logic [0:0]   s_tuser,   // [0] command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,   // [31:0] out_value, [63:32] out_priority,
                                         // [68:64] occupancy, [71:69] zero
    output logic [1:0]        m_tuser    // [1:0] status
);

    logic           item_valid;
    logic           item_pop;
    apq_pkg::item_t item;

    apq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser[0]),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    apq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/apq_front.sv =====
// Front end: accepts input words, decodes the command and buffers them
// in a two-entry queue for the back end. Depends on apq_pkg.
`default_nettype none

module apq_front (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [2*apq_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                       s_tuser,
    output logic                            item_valid,
    output apq_pkg::item_t                  item,
    input  wire logic                       item_pop
);

    apq_pkg::item_t buf_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    apq_pkg::item_t in_item;
    logic           push;

    always_comb begin
        in_item.op        = s_tuser ? apq_pkg::OP_DEQ : apq_pkg::OP_ENQ;
        in_item.value     = s_tdata[apq_pkg::DATA_W-1:0];
        in_item.entry_pri = s_tdata[2*apq_pkg::DATA_W-1:apq_pkg::DATA_W];
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/apq_core.sv =====
// Back end: entry store, fill count, sequential minimum scan and the
// output register. Depends on apq_pkg.
`default_nettype none

module apq_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  item_valid,
    input  wire apq_pkg::item_t        item,
    output logic                       item_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [71:0]                m_tdata,
    output logic [1:0]                 m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = 2 * apq_pkg::DATA_W;
    localparam int W  = apq_pkg::DATA_W;

    // entry store: {priority, value}
    logic [EW-1:0] mem [DEPTH];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;

    apq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   scan_idx_reg, scan_idx_next;
    logic            rd_valid_reg, rd_valid_next;
    logic [AW-1:0]   rd_idx_reg;
    logic [EW-1:0]   rd_data_reg;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic [W-1:0]    best_val_reg, best_val_next;
    logic [W-1:0]    best_pri_reg, best_pri_next;

    logic                  m_valid_reg, m_valid_next;
    apq_pkg::status_t      status_reg, status_next;
    logic [W-1:0]          out_val_reg, out_val_next;
    logic [W-1:0]          out_pri_reg, out_pri_next;
    logic [apq_pkg::OCC_W-1:0] occ_reg, occ_next;

    logic          out_free;
    logic [AW-1:0] last_idx;
    logic [CW-1:0] count_dec;
    logic [W-1:0]  rd_val;
    logic [W-1:0]  rd_pri;
    logic          take;

    assign out_free  = !m_valid_reg || m_tready;
    assign count_dec = count_reg - CW'(1);
    assign last_idx  = count_dec[AW-1:0];
    assign rd_val    = rd_data_reg[W-1:0];
    assign rd_pri    = rd_data_reg[EW-1:W];
    // later entry wins ties: replace when new <= best
    assign take      = (rd_idx_reg == '0) || ($signed(rd_pri) <= $signed(best_pri_reg));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        rd_valid_next = 1'b0;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        best_pri_next = best_pri_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        status_next   = status_reg;
        out_val_next  = out_val_reg;
        out_pri_next  = out_pri_reg;
        occ_next      = occ_reg;
        item_pop      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[AW-1:0];
        mem_wdata     = {item.entry_pri, item.value};
        mem_re        = 1'b0;

        if (rd_valid_reg && take) begin
            best_idx_next = rd_idx_reg;
            best_val_next = rd_val;
            best_pri_next = rd_pri;
        end

        unique case (state_reg)
            apq_pkg::S_IDLE: begin
                if (item_valid && out_free) begin
                    item_pop     = 1'b1;
                    out_val_next = '0;
                    out_pri_next = '0;
                    priority if (item.op == apq_pkg::OP_ENQ) begin
                        m_valid_next = 1'b1;
                        if (count_reg == CW'(DEPTH)) begin
                            status_next = apq_pkg::ST_FULL;
                            occ_next    = apq_pkg::OCC_W'(count_reg);
                        end else begin
                            mem_we      = 1'b1;
                            count_next  = count_reg + CW'(1);
                            status_next = apq_pkg::ST_ENQ;
                            occ_next    = apq_pkg::OCC_W'(count_next);
                        end
                    end else if (count_reg == '0) begin
                        m_valid_next = 1'b1;
                        status_next  = apq_pkg::ST_EMPTY;
                        occ_next     = apq_pkg::OCC_W'(count_reg);
                    end else begin
                        scan_idx_next = '0;
                        state_next    = apq_pkg::S_SCAN;
                    end
                end
            end
            apq_pkg::S_SCAN: begin
                mem_re        = 1'b1;
                rd_valid_next = 1'b1;
                scan_idx_next = scan_idx_reg + AW'(1);
                if (scan_idx_reg == last_idx) begin
                    state_next = apq_pkg::S_DRAIN;
                end
            end
            apq_pkg::S_DRAIN: begin
                // last entry is being compared; rd_data_reg keeps it
                state_next = apq_pkg::S_WRITE;
            end
            apq_pkg::S_WRITE: begin
                if (out_free) begin
                    mem_we       = 1'b1;
                    mem_waddr    = best_idx_reg;
                    mem_wdata    = rd_data_reg;
                    count_next   = count_dec;
                    m_valid_next = 1'b1;
                    status_next  = apq_pkg::ST_DEQ;
                    out_val_next = best_val_reg;
                    out_pri_next = best_pri_reg;
                    occ_next     = apq_pkg::OCC_W'(count_dec);
                    state_next   = apq_pkg::S_IDLE;
                end
            end
            default: state_next = apq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= apq_pkg::S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= scan_idx_reg;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        best_pri_reg <= best_pri_next;
        status_reg   <= status_next;
        out_val_reg  <= out_val_next;
        out_pri_reg  <= out_pri_next;
        occ_reg      <= occ_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, out_pri_reg, out_val_reg};

endmodule

`default_nettype wire
